FILE: rtl/rrmsl_pkg.sv
package rrmsl_pkg;

    localparam int CHAN_W = 4;

    localparam logic [CHAN_W-1:0] SEL_HI_MASK = 4'hC;
    localparam logic [CHAN_W-1:0] SEL_LO_MASK = 4'h3;
    localparam int SEL_SHIFT = 2;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_MEASURE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ACT,
        S_SHIFT,
        S_MEAS
    } t_state;

    function automatic logic [CHAN_W-1:0] select_code(input logic [CHAN_W-1:0] ch);
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] lo;
        hi = (ch & SEL_HI_MASK) >> SEL_SHIFT;
        lo = (ch & SEL_LO_MASK) << SEL_SHIFT;
        return hi | lo;
    endfunction

endpackage

FILE: rtl/rrmsl_ram.sv
module rrmsl_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/round_robin_measure_scan_list_core.sv
// The list RAM is walked one entry per cycle through its single read port, first to
// find the channel and then, for a remove, to close the gap. A new start is taken
// only once the previous item is done; busy drops as the result is presented, so
// the next start can coincide with the result transfer. The receiver cannot stall.
// Synchronous active-low reset empties the list, clears the cursor and the register.
module round_robin_measure_scan_list_core #(
    parameter int LIST_DEPTH  = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_func,
    input  logic [rrmsl_pkg::CHAN_W-1:0]      i_channel,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_done,
    output logic                              o_was_listed,
    output logic                              o_overflow,
    output logic                              o_none_queued,
    output logic [rrmsl_pkg::CHAN_W-1:0]      o_measured_channel,
    output logic [SAMPLE_BITS-1:0]            o_measured_value,
    output logic [rrmsl_pkg::CHAN_W-1:0]      o_demux_select
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CH_W  = rrmsl_pkg::CHAN_W;

    rrmsl_pkg::t_state r_state, n_state;
    rrmsl_pkg::t_func  r_func, n_func;

    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_cursor, n_cursor;
    logic                   r_reject;
    logic                   r_pend, n_pend;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_pos, n_pos;
    logic [IDX_W-1:0]       r_wr, n_wr;
    logic                   r_listed, n_listed;
    logic [CH_W-1:0]        r_chan, n_chan;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;

    logic                   r_res_listed, n_res_listed;
    logic                   r_res_ovf, n_res_ovf;
    logic                   r_res_none, n_res_none;
    logic [CH_W-1:0]        r_res_chan, n_res_chan;
    logic [SAMPLE_BITS-1:0] r_res_val, n_res_val;
    logic [CH_W-1:0]        r_res_sel, n_res_sel;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [CH_W-1:0]  ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [CH_W-1:0]  ram_rdata;

    logic             hit;
    logic             scan_end;
    logic             list_full;
    logic             list_empty;
    logic [IDX_W-1:0] cur_eff;
    logic [CNT_W-1:0] cur_inc;
    logic [IDX_W-1:0] cur_next;

    rrmsl_ram #(
        .WIDTH(CH_W),
        .DEPTH(LIST_DEPTH)
    ) u_list (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign hit        = r_pend && (ram_rdata == r_chan);
    assign scan_end   = (r_idx == r_count);
    assign list_full  = (r_count == CNT_W'(LIST_DEPTH));
    assign list_empty = (r_count == '0);
    assign cur_eff    = (CNT_W'(r_cursor) >= r_count) ? '0 : r_cursor;
    assign cur_inc    = CNT_W'(r_wr) + CNT_W'(1);
    assign cur_next   = (cur_inc >= r_count) ? '0 : cur_inc[IDX_W-1:0];

    assign busy        = (r_state != rrmsl_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rrmsl_pkg::S_IDLE: begin
                if (start) begin
                    n_state = rrmsl_pkg::S_SEARCH;
                end
            end
            rrmsl_pkg::S_SEARCH: begin
                if (hit || scan_end) begin
                    n_state = rrmsl_pkg::S_ACT;
                end
            end
            rrmsl_pkg::S_ACT: begin
                case (r_func)
                    rrmsl_pkg::FUNC_REMOVE: begin
                        n_state = r_listed ? rrmsl_pkg::S_SHIFT : rrmsl_pkg::S_IDLE;
                    end
                    rrmsl_pkg::FUNC_MEASURE: begin
                        n_state = list_empty ? rrmsl_pkg::S_IDLE : rrmsl_pkg::S_MEAS;
                    end
                    default: begin
                        n_state = rrmsl_pkg::S_IDLE;
                    end
                endcase
            end
            rrmsl_pkg::S_SHIFT: begin
                if (!r_pend && scan_end) begin
                    n_state = rrmsl_pkg::S_IDLE;
                end
            end
            rrmsl_pkg::S_MEAS: begin
                n_state = rrmsl_pkg::S_IDLE;
            end
            default: begin
                n_state = rrmsl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = r_chan;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        n_func       = r_func;
        n_chan       = r_chan;
        n_sample     = r_sample;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_pend       = r_pend;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_wr         = r_wr;
        n_listed     = r_listed;
        n_res_listed = r_res_listed;
        n_res_ovf    = r_res_ovf;
        n_res_none   = r_res_none;
        n_res_chan   = r_res_chan;
        n_res_val    = r_res_val;
        n_res_sel    = r_res_sel;
        n_done       = (r_state != rrmsl_pkg::S_IDLE) && (n_state == rrmsl_pkg::S_IDLE);
        case (r_state)
            rrmsl_pkg::S_IDLE: begin
                if (start) begin
                    n_func   = rrmsl_pkg::t_func'(i_func);
                    n_chan   = i_channel;
                    n_sample = i_sample;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_listed = 1'b0;
                end
            end
            rrmsl_pkg::S_SEARCH: begin
                if (hit) begin
                    n_listed = 1'b1;
                    n_pos    = r_idx - CNT_W'(1);
                    n_pend   = 1'b0;
                end else if (!scan_end) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            rrmsl_pkg::S_ACT: begin
                n_res_listed = r_listed;
                n_res_ovf    = 1'b0;
                n_res_none   = 1'b0;
                n_res_chan   = '0;
                n_res_val    = '0;
                n_res_sel    = '0;
                case (r_func)
                    rrmsl_pkg::FUNC_ADD: begin
                        if (!(r_reject && r_listed)) begin
                            if (list_full) begin
                                n_res_ovf = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IDX_W-1:0];
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                    end
                    rrmsl_pkg::FUNC_REMOVE: begin
                        n_idx  = r_pos + CNT_W'(1);
                        n_wr   = r_pos[IDX_W-1:0];
                        n_pend = 1'b0;
                    end
                    rrmsl_pkg::FUNC_MEASURE: begin
                        if (list_empty) begin
                            n_res_none = 1'b1;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = cur_eff;
                            n_wr      = cur_eff;
                        end
                    end
                    default: begin
                        n_res_ovf = 1'b0;
                    end
                endcase
            end
            rrmsl_pkg::S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr;
                    ram_wdata = ram_rdata;
                    n_wr      = r_wr + IDX_W'(1);
                end
                if (!scan_end) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && scan_end) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            rrmsl_pkg::S_MEAS: begin
                n_res_chan = ram_rdata;
                n_res_val  = r_sample;
                n_res_sel  = rrmsl_pkg::select_code(ram_rdata);
                n_cursor   = cur_next;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrmsl_pkg::S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_reject <= 1'b0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
            r_done   <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_reject <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_chan       <= n_chan;
        r_sample     <= n_sample;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_wr         <= n_wr;
        r_listed     <= n_listed;
        r_res_listed <= n_res_listed;
        r_res_ovf    <= n_res_ovf;
        r_res_none   <= n_res_none;
        r_res_chan   <= n_res_chan;
        r_res_val    <= n_res_val;
        r_res_sel    <= n_res_sel;
    end

    assign o_done             = r_done;
    assign o_was_listed       = r_res_listed;
    assign o_overflow         = r_res_ovf;
    assign o_none_queued      = r_res_none;
    assign o_measured_channel = r_res_chan;
    assign o_measured_value   = r_res_val;
    assign o_demux_select     = r_res_sel;

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAN_W = rrmsl_pkg::CHAN_W;
    localparam int DEPTH = 16;
    localparam int SMP_W = 10;
    localparam int RANDOM_PER_PHASE = 480;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    typedef struct packed {
        rrmsl_pkg::t_func  func;
        logic [CHAN_W-1:0] channel;
        logic [SMP_W-1:0]  sample;
    } t_scan_item;

    typedef struct packed {
        logic              was_listed;
        logic              overflow;
        logic              none_queued;
        logic [CHAN_W-1:0] chan;
        logic [SMP_W-1:0]  value;
        logic [CHAN_W-1:0] select;
    } t_scan_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_func = 2'd0;
    logic [CHAN_W-1:0] i_channel = '0;
    logic [SMP_W-1:0]  i_sample = '0;
    logic              o_done;
    logic              o_was_listed;
    logic              o_overflow;
    logic              o_none_queued;
    logic [CHAN_W-1:0] o_measured_channel;
    logic [SMP_W-1:0]  o_measured_value;
    logic [CHAN_W-1:0] o_demux_select;

    round_robin_measure_scan_list_core #(
        .LIST_DEPTH (DEPTH),
        .SAMPLE_BITS(SMP_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_channel         (i_channel),
        .i_sample          (i_sample),
        .o_done            (o_done),
        .o_was_listed      (o_was_listed),
        .o_overflow        (o_overflow),
        .o_none_queued     (o_none_queued),
        .o_measured_channel(o_measured_channel),
        .o_measured_value  (o_measured_value),
        .o_demux_select    (o_demux_select)
    );

    t_scan_item   pending_cmds[$];
    t_scan_result expected_results[$];
    t_scan_item   offered_cmd;
    int           sender_idle_pct = 0;
    int           error_count = 0;

    logic [CHAN_W-1:0] list_mem[DEPTH];
    logic [4:0]        list_len = '0;
    logic [CHAN_W-1:0] cursor = '0;
    logic              reject_dup = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_scan_result scan_list_step(t_scan_item it);
        t_scan_result r;
        logic [4:0]   pos;
        logic         hit;
        logic [4:0]   nxt;
        r = '0;
        pos = list_len;
        for (int i = int'(list_len) - 1; i >= 0; i--) begin
            if (list_mem[i] == it.channel) begin
                pos = 5'(i);
            end
        end
        hit = (pos < list_len);
        r.was_listed = hit;
        case (it.func)
            rrmsl_pkg::FUNC_ADD: begin
                if (!(reject_dup && hit)) begin
                    if (list_len >= 5'(DEPTH)) begin
                        r.overflow = 1'b1;
                    end else begin
                        list_mem[list_len[3:0]] = it.channel;
                        list_len = list_len + 5'd1;
                    end
                end
            end
            rrmsl_pkg::FUNC_REMOVE: begin
                if (hit) begin
                    for (int i = int'(pos); i + 1 < int'(list_len); i++) begin
                        list_mem[i] = list_mem[i+1];
                    end
                    list_len = list_len - 5'd1;
                end
            end
            rrmsl_pkg::FUNC_MEASURE: begin
                if (list_len == 5'd0) begin
                    r.none_queued = 1'b1;
                end else begin
                    if ({1'b0, cursor} >= list_len) begin
                        cursor = '0;
                    end
                    r.chan = list_mem[cursor];
                    r.value = it.sample;
                    r.select = {r.chan[1:0], r.chan[3:2]};
                    nxt = {1'b0, cursor} + 5'd1;
                    cursor = (nxt >= list_len) ? '0 : nxt[3:0];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(scan_list_step(offered_cmd));
            end
            if (!start || !busy) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    offered_cmd = pending_cmds.pop_front();
                    start <= 1'b1;
                    i_func <= offered_cmd.func;
                    i_channel <= offered_cmd.channel;
                    i_sample <= offered_cmd.sample;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_error(string what, t_scan_result exp_r, t_scan_result got_r);
        error_count++;
        if (error_count <= 10) begin
            $display("%s at %0t: expected listed=%0d ovf=%0d none=%0d ch=%0d val=%0d sel=%0d",
                     what, $time, exp_r.was_listed, exp_r.overflow, exp_r.none_queued,
                     exp_r.chan, exp_r.value, exp_r.select);
            $display("    got listed=%0d ovf=%0d none=%0d ch=%0d val=%0d sel=%0d",
                     got_r.was_listed, got_r.overflow, got_r.none_queued,
                     got_r.chan, got_r.value, got_r.select);
        end
    endtask

    always @(posedge i_clk) begin
        t_scan_result got_r;
        t_scan_result exp_r;
        if (i_rst_n && o_done) begin
            got_r = '{o_was_listed, o_overflow, o_none_queued,
                      o_measured_channel, o_measured_value, o_demux_select};
            if (expected_results.size() == 0) begin
                report_error("Unexpected result", '0, got_r);
            end else begin
                exp_r = expected_results.pop_front();
                if (got_r.was_listed !== exp_r.was_listed ||
                    got_r.overflow !== exp_r.overflow ||
                    got_r.none_queued !== exp_r.none_queued ||
                    got_r.chan !== exp_r.chan ||
                    got_r.value !== exp_r.value ||
                    got_r.select !== exp_r.select) begin
                    report_error("Result mismatch", exp_r, got_r);
                end
            end
        end
    end

    task automatic push_cmd(rrmsl_pkg::t_func f, logic [CHAN_W-1:0] ch, logic [SMP_W-1:0] s);
        pending_cmds.push_back(t_scan_item'{f, ch, s});
    endtask

    task automatic write_dup_mode(logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reject_dup = v;
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_scan_item random_cmd(int add_w, int rem_w, logic [CHAN_W-1:0] pool);
        t_scan_item it;
        int         roll;
        roll = $urandom_range(99);
        if (roll < add_w) begin
            it.func = rrmsl_pkg::FUNC_ADD;
        end else if (roll < add_w + rem_w) begin
            it.func = rrmsl_pkg::FUNC_REMOVE;
        end else begin
            it.func = rrmsl_pkg::FUNC_MEASURE;
        end
        if ($urandom_range(1) == 1) begin
            it.channel = pool + 4'($urandom_range(3));
        end else begin
            it.channel = 4'($urandom_range(15));
        end
        case ($urandom_range(9))
            0: it.sample = '0;
            1: it.sample = '1;
            default: it.sample = SMP_W'($urandom);
        endcase
        return it;
    endfunction

    task automatic queue_random_cmds(int count);
        int                queued;
        int                add_w;
        int                rem_w;
        logic [CHAN_W-1:0] pool;
        queued = 0;
        while (queued < count) begin
            case ($urandom_range(2))
                0: begin add_w = 75; rem_w = 10; end
                1: begin add_w = 35; rem_w = 30; end
                default: begin add_w = 15; rem_w = 55; end
            endcase
            pool = 4'($urandom_range(15));
            for (int i = 0; i < 40 && queued < count; i++) begin
                pending_cmds.push_back(random_cmd(add_w, rem_w, pool));
                queued++;
            end
        end
    endtask

    task automatic queue_directed_cmds();
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd6, 10'h3FF);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd3, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_ADD, 4'd0, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_ADD, 4'd15, 10'h3FF);
        push_cmd(rrmsl_pkg::FUNC_ADD, 4'd15, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_ADD, 4'd5, 10'h155);
        push_cmd(rrmsl_pkg::FUNC_ADD, 4'd10, 10'h2AA);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd0, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd15, 10'h3FF);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd9, 10'h2AA);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd5, 10'h155);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd10, 10'h001);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd1, 10'h200);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd15, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd15, 10'h3FF);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd7, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd2, 10'h0F0);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd10, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd5, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd12, 10'h30C);
        push_cmd(rrmsl_pkg::FUNC_REMOVE, 4'd0, 10'h000);
        push_cmd(rrmsl_pkg::FUNC_MEASURE, 4'd0, 10'h3FF);
    endtask

    initial begin
        int   idle_by_phase[4];
        logic dup_by_phase[4];
        idle_by_phase = '{0, 79, 32, 0};
        dup_by_phase = '{1'b0, 1'b1, 1'b0, 1'b1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            write_dup_mode(dup_by_phase[p]);
            sender_idle_pct = idle_by_phase[p];
            if (p == 0) begin
                queue_directed_cmds();
            end
            if (p == 1) begin
                // Second add of a listed channel must be refused without overflow.
                push_cmd(rrmsl_pkg::FUNC_ADD, 4'd4, 10'h011);
                push_cmd(rrmsl_pkg::FUNC_ADD, 4'd4, 10'h022);
            end
            queue_random_cmds(RANDOM_PER_PHASE);
            wait_quiet();
        end
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rrmsl_pkg.sv
rtl/rrmsl_ram.sv
rtl/round_robin_measure_scan_list_core.sv
tb/tb.sv
